>>> rtl/bitmap_page_allocator_unit_defines.svh
// Assertion macros shared by the bitmap page allocator RTL.
// Included by the modules that carry concurrent assertions.
`ifndef BITMAP_PAGE_ALLOCATOR_UNIT_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_UNIT_DEFINES_SVH

// The consequent must hold whenever the antecedent holds, outside reset.
`define BPA_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The condition must hold at every clock edge outside reset.
`define BPA_ASSERT_ALWAYS(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

>>> rtl/bpa_pkg.sv
// Package of the bitmap page allocator: widths, opcodes, status codes and
// the request, response, command and configuration types. No dependencies.
`default_nettype none

package bpa_pkg;

    localparam int unsigned MAX_PAGES_DEF     = 1048576;
    localparam int unsigned MAP_WORD_BITS_DEF = 32;
    localparam int unsigned PAGE_BYTES        = 4096;
    localparam int unsigned PAGE_SHIFT        = $clog2(PAGE_BYTES);
    localparam int unsigned ADDR_W            = 32;
    localparam int unsigned PAGE_W            = ADDR_W - PAGE_SHIFT;
    localparam int unsigned CNT_W             = 21;
    localparam int unsigned OP_W              = 3;
    localparam int unsigned ST_W              = 3;
    localparam int unsigned CFG_IDX_W         = 3;
    localparam int unsigned QUEUE_DEPTH       = 2;
    localparam int unsigned LOW_MB_BYTES      = 1024 * 1024;

    // Opcodes.
    localparam logic [OP_W-1:0] OP_ALLOC      = 3'd0;
    localparam logic [OP_W-1:0] OP_FREE       = 3'd1;
    localparam logic [OP_W-1:0] OP_QUERY      = 3'd2;
    localparam logic [OP_W-1:0] OP_MARK_ALLOC = 3'd3;
    localparam logic [OP_W-1:0] OP_MARK_FREE  = 3'd4;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK         = 3'd0;
    localparam logic [ST_W-1:0] ST_MISALIGNED = 3'd1;
    localparam logic [ST_W-1:0] ST_RESERVED   = 3'd2;
    localparam logic [ST_W-1:0] ST_RANGE      = 3'd3;
    localparam logic [ST_W-1:0] ST_NONE       = 3'd4;
    localparam logic [ST_W-1:0] ST_ALREADY    = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PAGES  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_FIRST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_END   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_FIRST    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_END      = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [ADDR_W-1:0] address;
    } t_req;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [ADDR_W-1:0] page_address;
        logic              is_free;
        logic [CNT_W-1:0]  free_pages;
    } t_resp;

    // What the back end has to do with a classified request.
    typedef enum logic [2:0] {
        K_REPLY,
        K_ALLOC,
        K_FREE,
        K_QUERY,
        K_MARK_ALLOC,
        K_MARK_FREE
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [ST_W-1:0]   status;
        logic [PAGE_W-1:0] page;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] total_pages;
        logic [CNT_W-1:0] kernel_first_page;
        logic [CNT_W-1:0] kernel_end_page;
        logic [CNT_W-1:0] map_first_page;
        logic [CNT_W-1:0] map_end_page;
    } t_cfg;

    // Number of reachable pages: total_pages clipped to the map size.
    function automatic logic [CNT_W-1:0] page_limit(input logic [CNT_W-1:0] total,
                                                    input logic [CNT_W-1:0] max_pages);
        return (total > max_pages) ? max_pages : total;
    endfunction

endpackage

`default_nettype wire

>>> rtl/bpa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bpa_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32768
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                            i_wdata,
    input  wire logic                                        i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/bpa_front.sv
// Front end of the page allocator: accepts requests and classifies them into
// back-end commands, settling every address check. Depends on bpa_pkg.
`default_nettype none

module bpa_front #(
    parameter int unsigned MAX_PAGES = bpa_pkg::MAX_PAGES_DEF
) (
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire bpa_pkg::t_req i_in_req,
    input  wire bpa_pkg::t_cfg i_cfg,
    input  wire logic          i_clearing,
    input  wire logic          i_q_full,
    output logic               o_push,
    output bpa_pkg::t_cmd      o_cmd
);

    import bpa_pkg::*;

    localparam logic [CNT_W-1:0] MaxPagesC = CNT_W'(MAX_PAGES);

    logic              aligned;
    logic [PAGE_W-1:0] page;
    logic [CNT_W-1:0]  page_ext;
    logic [CNT_W-1:0]  limit;
    logic              low_mb;
    logic              in_kernel;
    logic              in_map;
    logic              out_range;

    assign o_in_ready = !i_clearing && !i_q_full;
    assign o_push     = i_in_valid && o_in_ready;

    always_comb begin
        aligned   = (i_in_req.address[PAGE_SHIFT-1:0] == '0);
        page      = i_in_req.address[ADDR_W-1:PAGE_SHIFT];
        page_ext  = CNT_W'(page);
        limit     = page_limit(i_cfg.total_pages, MaxPagesC);
        low_mb    = (i_in_req.address < ADDR_W'(LOW_MB_BYTES));
        in_kernel = (page_ext >= i_cfg.kernel_first_page) &&
                    (page_ext < i_cfg.kernel_end_page);
        in_map    = (page_ext >= i_cfg.map_first_page) && (page_ext < i_cfg.map_end_page);
        out_range = (page_ext >= limit);

        o_cmd.kind   = K_REPLY;
        o_cmd.status = ST_OK;
        o_cmd.page   = page;

        case (i_in_req.opcode)
            OP_ALLOC: begin
                o_cmd.kind = K_ALLOC;
            end
            OP_FREE: begin
                if (!aligned) begin
                    o_cmd.status = ST_MISALIGNED;
                end else if (low_mb || in_kernel || in_map) begin
                    o_cmd.status = ST_RESERVED;
                end else if (out_range) begin
                    o_cmd.status = ST_RANGE;
                end else begin
                    o_cmd.kind = K_FREE;
                end
            end
            OP_QUERY, OP_MARK_ALLOC, OP_MARK_FREE: begin
                if (!aligned) begin
                    o_cmd.status = ST_MISALIGNED;
                end else if (out_range) begin
                    o_cmd.status = ST_RANGE;
                end else if (i_in_req.opcode == OP_QUERY) begin
                    o_cmd.kind = K_QUERY;
                end else if (i_in_req.opcode == OP_MARK_ALLOC) begin
                    o_cmd.kind = K_MARK_ALLOC;
                end else begin
                    o_cmd.kind = K_MARK_FREE;
                end
            end
            default: begin
                // Unknown opcodes answer ok and touch nothing.
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/bpa_queue.sv
// Small command FIFO between the allocator front end and back end.
// Depends on bpa_pkg.
`default_nettype none

module bpa_queue #(
    parameter int unsigned DEPTH = bpa_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire bpa_pkg::t_cmd i_cmd,
    output logic               o_full,
    output logic               o_valid,
    output bpa_pkg::t_cmd      o_cmd,
    input  wire logic          i_pop
);

    import bpa_pkg::*;

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic [PtrW-1:0] n_wr_ptr;
    logic [PtrW-1:0] n_rd_ptr;
    logic [CntW-1:0] n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

>>> rtl/bpa_back.sv
// Back end of the page allocator: owns the bitmap RAM, the free counter, the
// first-fit scan and the response register. Depends on bpa_pkg and bpa_ram.
`default_nettype none
`include "bitmap_page_allocator_unit_defines.svh"

module bpa_back #(
    parameter int unsigned MAX_PAGES     = bpa_pkg::MAX_PAGES_DEF,
    parameter int unsigned MAP_WORD_BITS = bpa_pkg::MAP_WORD_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [bpa_pkg::CNT_W-1:0]      i_total_pages,
    input  wire logic                           i_q_valid,
    input  wire bpa_pkg::t_cmd                  i_cmd,
    output logic                                o_q_pop,
    output logic                                o_clearing,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output bpa_pkg::t_resp                      o_out_resp
);

    import bpa_pkg::*;

    localparam int unsigned Words = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int unsigned AW    = (Words > 1) ? $clog2(Words) : 1;
    localparam int unsigned HW    = AW + 1;
    localparam int unsigned BW    = $clog2(MAP_WORD_BITS);
    localparam logic [CNT_W-1:0] MaxPagesC = CNT_W'(MAX_PAGES);
    localparam logic [MAP_WORD_BITS-1:0] OneBit = {{(MAP_WORD_BITS - 1){1'b0}}, 1'b1};

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_SCAN
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [AW-1:0]      r_clr_addr;
    logic [AW-1:0]      n_clr_addr;
    t_cmd               r_cmd;
    t_cmd               n_cmd;
    logic [AW-1:0]      r_scan;
    logic [AW-1:0]      n_scan;
    logic [HW-1:0]      r_hint;
    logic [HW-1:0]      n_hint;
    logic [CNT_W-1:0]   r_free_count;
    logic [CNT_W-1:0]   n_free_count;
    logic               r_out_valid;
    logic               n_out_valid;
    t_resp              r_out_resp;
    t_resp              n_out_resp;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [MAP_WORD_BITS-1:0] ram_wdata;
    logic                     ram_re;
    logic [AW-1:0]            ram_raddr;
    logic [MAP_WORD_BITS-1:0] ram_rdata;

    logic [CNT_W-1:0]         limit;
    logic                     out_free;
    logic                     load;
    logic [ST_W-1:0]          res_status;
    logic [ADDR_W-1:0]        res_addr;
    logic                     res_is_free;
    logic [AW-1:0]            cmd_word;
    logic [AW-1:0]            new_word;
    logic [BW-1:0]            bit_pos;
    logic [MAP_WORD_BITS-1:0] bit_mask;
    logic                     page_bit;
    logic                     found;
    logic [BW-1:0]            zero_pos;
    logic [MAP_WORD_BITS-1:0] zero_mask;
    logic [ADDR_W-1:0]        alloc_page;
    logic [HW-1:0]            next_word;

    bpa_ram #(
        .WIDTH (MAP_WORD_BITS),
        .DEPTH (Words)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        limit      = page_limit(i_total_pages, MaxPagesC);
        out_free   = !r_out_valid || i_out_ready;
        cmd_word   = AW'(r_cmd.page >> BW);
        new_word   = AW'(i_cmd.page >> BW);
        bit_pos    = r_cmd.page[BW-1:0];
        bit_mask   = OneBit << bit_pos;
        page_bit   = ram_rdata[bit_pos];

        // Lowest clear bit of the word on the read port.
        found    = 1'b0;
        zero_pos = '0;
        for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
            if (!ram_rdata[i]) begin
                found    = 1'b1;
                zero_pos = BW'(i);
            end
        end
        zero_mask  = OneBit << zero_pos;
        alloc_page = (ADDR_W'(r_scan) << BW) | ADDR_W'(zero_pos);
        next_word  = HW'(r_scan) + 1'b1;

        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_cmd        = r_cmd;
        n_scan       = r_scan;
        n_hint       = r_hint;
        n_free_count = r_free_count;
        ram_we       = 1'b0;
        ram_waddr    = cmd_word;
        ram_wdata    = ram_rdata;
        ram_re       = 1'b0;
        ram_raddr    = new_word;
        o_q_pop      = 1'b0;
        load         = 1'b0;
        res_status   = ST_OK;
        res_addr     = '0;
        res_is_free  = 1'b0;

        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '1;
                if (r_clr_addr == AW'(Words - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_cmd;
                    case (i_cmd.kind)
                        K_ALLOC: begin
                            if ((ADDR_W'(r_hint) << BW) >= ADDR_W'(limit)) begin
                                load       = 1'b1;
                                res_status = ST_NONE;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = AW'(r_hint);
                                n_scan    = AW'(r_hint);
                                n_state   = S_SCAN;
                            end
                        end
                        K_FREE, K_QUERY, K_MARK_ALLOC, K_MARK_FREE: begin
                            ram_re  = 1'b1;
                            n_state = S_EXEC;
                        end
                        default: begin
                            load       = 1'b1;
                            res_status = i_cmd.status;
                        end
                    endcase
                end
            end
            S_EXEC: begin
                load    = 1'b1;
                n_state = S_IDLE;
                case (r_cmd.kind)
                    K_FREE: begin
                        if (!page_bit) begin
                            res_status = ST_ALREADY;
                        end else begin
                            ram_we       = 1'b1;
                            ram_wdata    = ram_rdata & ~bit_mask;
                            n_free_count = r_free_count + 1'b1;
                            if (HW'(cmd_word) < r_hint) begin
                                n_hint = HW'(cmd_word);
                            end
                        end
                    end
                    K_QUERY: begin
                        res_is_free = !page_bit;
                    end
                    K_MARK_ALLOC: begin
                        if (!page_bit) begin
                            ram_we       = 1'b1;
                            ram_wdata    = ram_rdata | bit_mask;
                            n_free_count = r_free_count - 1'b1;
                        end
                    end
                    K_MARK_FREE: begin
                        if (page_bit) begin
                            ram_we       = 1'b1;
                            ram_wdata    = ram_rdata & ~bit_mask;
                            n_free_count = r_free_count + 1'b1;
                            if (HW'(cmd_word) < r_hint) begin
                                n_hint = HW'(cmd_word);
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                if (found) begin
                    load    = 1'b1;
                    n_state = S_IDLE;
                    if (alloc_page < ADDR_W'(limit)) begin
                        ram_we       = 1'b1;
                        ram_waddr    = r_scan;
                        ram_wdata    = ram_rdata | zero_mask;
                        n_free_count = r_free_count - 1'b1;
                        n_hint       = ((ram_rdata | zero_mask) == '1) ? next_word
                                                                      : HW'(r_scan);
                        res_addr     = alloc_page << PAGE_SHIFT;
                    end else begin
                        res_status = ST_NONE;
                    end
                end else begin
                    // Every word up to this one is full.
                    n_hint = next_word;
                    if ((ADDR_W'(next_word) << BW) >= ADDR_W'(limit)) begin
                        load       = 1'b1;
                        res_status = ST_NONE;
                        n_state    = S_IDLE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = AW'(next_word);
                        n_scan    = AW'(next_word);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = r_out_valid && !i_out_ready;
        n_out_resp  = r_out_resp;
        if (load) begin
            n_out_valid             = 1'b1;
            n_out_resp.status       = res_status;
            n_out_resp.page_address = res_addr;
            n_out_resp.is_free      = res_is_free;
            n_out_resp.free_pages   = n_free_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_hint       <= '0;
            r_free_count <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_cmd        <= n_cmd;
            r_scan       <= n_scan;
            r_hint       <= n_hint;
            r_free_count <= n_free_count;
            r_out_valid  <= n_out_valid;
            r_out_resp   <= n_out_resp;
        end
    end

    assign o_clearing  = (r_state == S_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_out_resp  = r_out_resp;

    `BPA_ASSERT_IMP(a_no_pop_in_clear, i_clk, i_rst_n, r_state == S_CLEAR, !o_q_pop, "command popped during clearing pass")
    `BPA_ASSERT_IMP(a_no_write_in_idle, i_clk, i_rst_n, ram_we, r_state != S_IDLE, "bitmap written while idle")
    `BPA_ASSERT_IMP(a_load_into_free_slot, i_clk, i_rst_n, load, out_free, "response overwritten before it was taken")
    `BPA_ASSERT_ALWAYS(a_count_bounded, i_clk, i_rst_n, r_free_count <= MaxPagesC, "free count exceeds map size")

endmodule

`default_nettype wire

>>> rtl/bitmap_page_allocator_unit.sv
// Bitmap page allocator top level: configuration registers, front end, command queue and
// back end with the bitmap RAM. Depends on bpa_pkg, bpa_front, bpa_queue, bpa_back.
// An error reply passes through the queue into the response register; free, query and
// marks read one bitmap word and write it back only if a page bit changes; alloc scans
// one map word per cycle from the lowest word that may hold a free page.
// After reset a clearing pass over every map word (32768 by default) sets every page
// allocated; requests are held off until it ends, configuration is taken always.
`default_nettype none

module bitmap_page_allocator_unit #(
    parameter int unsigned MAX_PAGES     = bpa_pkg::MAX_PAGES_DEF,
    parameter int unsigned MAP_WORD_BITS = bpa_pkg::MAP_WORD_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [bpa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [bpa_pkg::CNT_W-1:0]         i_cfg_wdata,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire bpa_pkg::t_req                     i_in_req,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output bpa_pkg::t_resp                         o_out_resp
);

    import bpa_pkg::*;

    // Configuration registers. Writes must only happen while the block is idle, which the block
    // itself does not enforce, so both halves may read them directly without any snapshot.
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_TOTAL_PAGES:  r_cfg.total_pages       <= i_cfg_wdata;
                CFG_KERNEL_FIRST: r_cfg.kernel_first_page <= i_cfg_wdata;
                CFG_KERNEL_END:   r_cfg.kernel_end_page   <= i_cfg_wdata;
                CFG_MAP_FIRST:    r_cfg.map_first_page    <= i_cfg_wdata;
                CFG_MAP_END:      r_cfg.map_end_page      <= i_cfg_wdata;
                default: begin
                    // Writes beyond the register list are dropped.
                end
            endcase
        end
    end

    logic q_push;
    logic q_full;
    logic q_valid;
    logic q_pop;
    logic clearing;
    t_cmd front_cmd;
    t_cmd q_cmd;

    // The front end resolves alignment, protected ranges and the page limit
    // in the accepting cycle, so the back end only sees real bitmap work
    // or a ready-made reply.
    bpa_front #(
        .MAX_PAGES (MAX_PAGES)
    ) u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_req   (i_in_req),
        .i_cfg      (r_cfg),
        .i_clearing (clearing),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_cmd      (front_cmd)
    );

    // The queue lets new requests be taken while the back end scans or
    // while a finished response waits for the consumer.
    bpa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    // The back end holds the bitmap, the free counter, a hint of the
    // lowest word that may hold a free page, and the response register.
    bpa_back #(
        .MAX_PAGES     (MAX_PAGES),
        .MAP_WORD_BITS (MAP_WORD_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_total_pages (r_cfg.total_pages),
        .i_q_valid     (q_valid),
        .i_cmd         (q_cmd),
        .o_q_pop       (q_pop),
        .o_clearing    (clearing),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_resp    (o_out_resp)
    );

endmodule

`default_nettype wire

>>> verif/bitmap_page_allocator_unit_test.sv
// Self-checking testbench for the bitmap page allocator: a directed table, then random phases
// under several register settings, each reply checked against the table or a local predictor.
// Depends on bpa_pkg and bitmap_page_allocator_unit.
module bitmap_page_allocator_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bpa_pkg::*;

    // The shadow bitmap is kept in words of the same shape as the block's map, so the
    // predicted first-fit scan and its cost in cycles can both be read off directly.
    localparam int unsigned MAP_WORDS    = MAX_PAGES_DEF / MAP_WORD_BITS_DEF;
    localparam int unsigned LOW_MB_PAGE  = LOW_MB_BYTES >> PAGE_SHIFT;
    // An alloc whose scan passes more words than this is a long scan; only three are
    // allowed in the random part, since each one may scan most of the map.
    localparam int unsigned SHORT_SCAN   = 64;
    // Cycles without any accepted request or reply before the run is declared hung. It
    // covers the clearing pass after reset and a scan over the whole map, several times.
    localparam int unsigned STALL_LIMIT  = 300000;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int          FEED         = 0;
    localparam int          SINK         = 1;
    localparam int          PHASES       = 5;

    typedef struct {
        bit                   is_setting;
        logic [CFG_IDX_W-1:0] reg_index;
        logic [CNT_W-1:0]     reg_value;
        t_req                 rq;
        bit                   typed;
        t_resp                known;
    } t_plan_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CNT_W-1:0] i_cfg_wdata;
    logic i_in_valid;
    logic o_in_ready;
    t_req i_in_req;
    logic o_out_valid;
    logic i_out_ready;
    t_resp o_out_resp;

    // Shadow state of the allocator: 1 in the map means allocated.
    logic [MAP_WORD_BITS_DEF-1:0] shadow_map [MAP_WORDS];
    logic [CNT_W-1:0]             shadow_free;
    t_cfg                         shadow_cfg;

    t_resp             pending_replies [$];
    logic [ADDR_W-1:0] handed_out [$];
    t_plan_row         plan [$];
    int unsigned       mismatches;
    int unsigned       replies_seen;
    int unsigned       idle_cycles;
    int unsigned       long_scans_left = 3;
    int unsigned       idle_run [2];
    bit                idle_off [2];

    bitmap_page_allocator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_resp  (o_out_resp)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Number of reachable pages: total_pages saturates at the size of the map.
    function automatic int unsigned page_cap();
        return (shadow_cfg.total_pages > MAX_PAGES_DEF) ? MAX_PAGES_DEF
                                                        : int'(shadow_cfg.total_pages);
    endfunction

    // Index of the lowest map word with a free bit, or MAP_WORDS if none has one.
    function automatic int unsigned first_open_word();
        for (int unsigned w = 0; w < MAP_WORDS; w++) begin
            if (shadow_map[w] != '1) return w;
        end
        return MAP_WORDS;
    endfunction

    // The free count only moves on a real change of a page bit.
    function automatic void put_page(input int unsigned page, input bit taken);
        int unsigned w;
        int unsigned b;
        w = page / MAP_WORD_BITS_DEF;
        b = page % MAP_WORD_BITS_DEF;
        if (taken && !shadow_map[w][b]) begin
            shadow_map[w][b] = 1'b1;
            shadow_free = shadow_free - 1'b1;
        end else if (!taken && shadow_map[w][b]) begin
            shadow_map[w][b] = 1'b0;
            shadow_free = shadow_free + 1'b1;
        end
    endfunction

    // Works out the reply to one request and updates the shadow state.
    function automatic t_resp reply_for(input t_req rq);
        t_resp       rs;
        int unsigned page;
        int unsigned lim;
        int unsigned w;
        int unsigned b;
        bit          aligned;
        rs = '0;
        page = rq.address >> PAGE_SHIFT;
        aligned = (rq.address[PAGE_SHIFT-1:0] == '0);
        lim = page_cap();
        case (rq.opcode)
            OP_ALLOC: begin
                // First fit: the first word with a free bit decides. If that bit lies
                // beyond the managed range the answer is none free, even if a lower
                // page could never have been free.
                rs.status = ST_NONE;
                w = first_open_word();
                if (w < MAP_WORDS) begin
                    b = 0;
                    while (shadow_map[w][b]) b++;
                    if (w * MAP_WORD_BITS_DEF + b < lim) begin
                        put_page(w * MAP_WORD_BITS_DEF + b, 1'b1);
                        rs.page_address = (w * MAP_WORD_BITS_DEF + b) << PAGE_SHIFT;
                        rs.status = ST_OK;
                    end
                end
            end
            OP_FREE: begin
                // The checks run in this order; the first that hits gives the status.
                if (!aligned) rs.status = ST_MISALIGNED;
                else if (rq.address < LOW_MB_BYTES) rs.status = ST_RESERVED;
                else if (page >= shadow_cfg.kernel_first_page &&
                         page < shadow_cfg.kernel_end_page) rs.status = ST_RESERVED;
                else if (page >= shadow_cfg.map_first_page &&
                         page < shadow_cfg.map_end_page) rs.status = ST_RESERVED;
                else if (page >= lim) rs.status = ST_RANGE;
                else if (!shadow_map[page / MAP_WORD_BITS_DEF][page % MAP_WORD_BITS_DEF])
                    rs.status = ST_ALREADY;
                else put_page(page, 1'b0);
            end
            OP_QUERY, OP_MARK_ALLOC, OP_MARK_FREE: begin
                // Queries and marks skip the protection checks.
                if (!aligned) rs.status = ST_MISALIGNED;
                else if (page >= lim) rs.status = ST_RANGE;
                else if (rq.opcode == OP_QUERY)
                    rs.is_free = !shadow_map[page / MAP_WORD_BITS_DEF][page % MAP_WORD_BITS_DEF];
                else put_page(page, rq.opcode == OP_MARK_ALLOC);
            end
            default: ;  // Codes above mark free do nothing and answer ok.
        endcase
        rs.free_pages = shadow_free;
        return rs;
    endfunction

    // Each side draws its wait for every item. Each run of items picks, one time in four, a calm
    // mode with no idling at all, and otherwise a mode with a random wait before each item.
    function automatic int unsigned draw_wait(input int side);
        if (idle_run[side] == 0) begin
            idle_off[side] = ($urandom_range(0, 3) == 0);
            idle_run[side] = $urandom_range(5, 40);
        end
        idle_run[side]--;
        return idle_off[side] ? 0 : $urandom_range(0, 17);
    endfunction

    task automatic report(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic t_plan_row setting_row(input logic [CFG_IDX_W-1:0] idx,
                                              input logic [CNT_W-1:0] val);
        t_plan_row r;
        r.is_setting = 1'b1;
        r.reg_index = idx;
        r.reg_value = val;
        r.rq = '0;
        r.typed = 1'b0;
        r.known = '0;
        return r;
    endfunction

    function automatic t_plan_row request_row(input logic [OP_W-1:0] op,
                                              input logic [ADDR_W-1:0] addr);
        t_plan_row r;
        r = setting_row(CFG_TOTAL_PAGES, '0);
        r.is_setting = 1'b0;
        r.rq.opcode = op;
        r.rq.address = addr;
        return r;
    endfunction

    // A row whose reply is written down directly: only the status is nonzero.
    function automatic t_plan_row known_row(input logic [OP_W-1:0] op,
                                            input logic [ADDR_W-1:0] addr,
                                            input logic [ST_W-1:0] st);
        t_plan_row r;
        r = request_row(op, addr);
        r.typed = 1'b1;
        r.known.status = st;
        return r;
    endfunction

    // Page numbers for random requests: mostly low pages, often the edges of the
    // protected ranges and of the managed range, now and then anywhere at all.
    function automatic logic [PAGE_W-1:0] pick_page(input int unsigned lim);
        int unsigned edges [6];
        int unsigned roll;
        int unsigned span;
        edges[0] = LOW_MB_PAGE;
        edges[1] = shadow_cfg.kernel_first_page;
        edges[2] = shadow_cfg.kernel_end_page;
        edges[3] = shadow_cfg.map_first_page;
        edges[4] = shadow_cfg.map_end_page;
        edges[5] = lim;
        roll = $urandom_range(0, 9);
        span = (lim < 1024) ? lim : 1024;
        if (roll < 6) return PAGE_W'($urandom_range(0, span + 8));
        if (roll < 9) return PAGE_W'(edges[$urandom_range(0, 5)] + $urandom_range(0, 2) - 1);
        return PAGE_W'($urandom());
    endfunction

    function automatic t_req random_request();
        t_req        rq;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        rq.address = {pick_page(page_cap()), {PAGE_SHIFT{1'b0}}};
        if (roll < 30) begin
            rq.opcode = OP_ALLOC;
            // A scan past the first SHORT_SCAN map words is allowed only three times; past that the
            // request turns into a query.
            if (first_open_word() > SHORT_SCAN) begin
                if (long_scans_left != 0) long_scans_left--;
                else rq.opcode = OP_QUERY;
            end
        end else if (roll < 55) begin
            rq.opcode = OP_FREE;
            // Half of the frees give back a page that an earlier alloc handed out.
            if (handed_out.size() != 0 && $urandom_range(0, 1) == 1)
                rq.address = handed_out.pop_front();
        end else if (roll < 68) begin
            rq.opcode = OP_QUERY;
        end else if (roll < 78) begin
            rq.opcode = OP_MARK_ALLOC;
        end else if (roll < 90) begin
            rq.opcode = OP_MARK_FREE;
        end else if (roll < 96) begin
            // Free, query or a mark, on an address that is not page aligned.
            rq.opcode = OP_FREE + OP_W'($urandom_range(0, 3));
            rq.address = $urandom();
            if (rq.address[PAGE_SHIFT-1:0] == '0) rq.address[0] = 1'b1;
        end else begin
            rq.opcode = OP_MARK_FREE + OP_W'($urandom_range(1, 3));
            rq.address = $urandom();
        end
        return rq;
    endfunction

    // Presents one request after the drawn gap and waits for it to be taken. The
    // prediction is made at the accepting edge, so requests are predicted in order.
    task automatic issue(input t_req rq, input bit typed, input t_resp known);
        int unsigned gap;
        t_resp       want;
        gap = draw_wait(FEED);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req <= rq;
        do @(posedge i_clk); while (!o_in_ready);
        want = reply_for(rq);
        if (rq.opcode == OP_ALLOC && want.status == ST_OK && handed_out.size() < 64)
            handed_out.push_back(want.page_address);
        pending_replies.push_back(typed ? known : want);
    endtask

    // Holds the sender until every reply that is owed has come back.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_TOTAL_PAGES:  shadow_cfg.total_pages = val;
            CFG_KERNEL_FIRST: shadow_cfg.kernel_first_page = val;
            CFG_KERNEL_END:   shadow_cfg.kernel_end_page = val;
            CFG_MAP_FIRST:    shadow_cfg.map_first_page = val;
            CFG_MAP_END:      shadow_cfg.map_end_page = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input t_cfg c);
        settle();
        write_reg(CFG_TOTAL_PAGES, c.total_pages);
        write_reg(CFG_KERNEL_FIRST, c.kernel_first_page);
        write_reg(CFG_KERNEL_END, c.kernel_end_page);
        write_reg(CFG_MAP_FIRST, c.map_first_page);
        write_reg(CFG_MAP_END, c.map_end_page);
    endtask

    initial begin : stimulus
        t_cfg        phase_cfg [PHASES];
        int unsigned phase_items [PHASES];
        i_rst_n <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= CFG_TOTAL_PAGES;
        i_cfg_wdata <= '0;
        i_in_valid <= 1'b0;
        i_in_req <= '0;
        foreach (shadow_map[w]) shadow_map[w] = '1;
        shadow_free = '0;
        shadow_cfg = '0;

        // Straight out of reset nothing is managed: every page is allocated and every
        // register is zero, so each reply below is only a status with a zero count.
        plan.push_back(known_row(OP_ALLOC, 32'h0000_0000, ST_NONE));
        plan.push_back(known_row(OP_FREE, 32'hFFFF_FFFF, ST_MISALIGNED));
        plan.push_back(known_row(OP_FREE, 32'h0000_0000, ST_RESERVED));
        plan.push_back(known_row(OP_FREE, 32'h0010_0000, ST_RANGE));
        plan.push_back(known_row(OP_QUERY, 32'hFFFF_F000, ST_RANGE));
        plan.push_back(known_row(OP_MARK_FREE, 32'h0000_0000, ST_RANGE));
        plan.push_back(known_row(OP_MARK_FREE + 3'd1, 32'h0000_0000, ST_OK));
        plan.push_back(known_row(OP_MARK_FREE + 3'd3, 32'hFFFF_FFFF, ST_OK));
        // A small map with the kernel on pages 256 to 259 and the bitmap on 300 and 301.
        plan.push_back(setting_row(CFG_TOTAL_PAGES, 21'd1024));
        plan.push_back(setting_row(CFG_KERNEL_FIRST, 21'd256));
        plan.push_back(setting_row(CFG_KERNEL_END, 21'd260));
        plan.push_back(setting_row(CFG_MAP_FIRST, 21'd300));
        plan.push_back(setting_row(CFG_MAP_END, 21'd302));
        plan.push_back(request_row(OP_MARK_FREE, 32'h0000_0000));
        plan.push_back(request_row(OP_MARK_FREE, 32'h0000_1000));
        plan.push_back(request_row(OP_QUERY, 32'h0000_0000));
        plan.push_back(request_row(OP_ALLOC, 32'h0000_0000));
        plan.push_back(request_row(OP_ALLOC, 32'h0000_0000));
        plan.push_back(request_row(OP_FREE, 32'h000F_F000));  // last page below 1 MB
        plan.push_back(request_row(OP_FREE, 32'h0010_0000));  // first kernel page
        plan.push_back(request_row(OP_FREE, 32'h0010_4000));  // just past the kernel
        plan.push_back(request_row(OP_FREE, 32'h0012_C000));  // first bitmap page
        plan.push_back(request_row(OP_FREE, 32'h0012_E000));  // just past the bitmap
        plan.push_back(request_row(OP_FREE, 32'h0012_E000));  // same page again
        plan.push_back(request_row(OP_FREE, 32'h0040_0000));  // first page out of range
        plan.push_back(request_row(OP_FREE, 32'h003F_F000));  // last page in range
        plan.push_back(request_row(OP_QUERY, 32'h003F_F000));
        plan.push_back(request_row(OP_MARK_ALLOC, 32'h003F_F000));
        plan.push_back(request_row(OP_ALLOC, 32'h0000_0000));
        plan.push_back(request_row(OP_FREE, 32'h0010_4001));

        // Random phases: a plain small map; the total page register at its top value with no
        // protection; a tiny map fully covered by the kernel; an inverted kernel range
        // with the bitmap overlapping it; and a map that shrinks below pages in use.
        phase_cfg[0] = '{21'd1024, 21'd256, 21'd288, 21'd288, 21'd296};
        phase_cfg[1] = '{21'h1F_FFFF, 21'h1F_FFFF, 21'h1F_FFFF, 21'd0, 21'd0};
        phase_cfg[2] = '{21'd64, 21'd0, 21'h1F_FFFF, 21'd0, 21'd0};
        phase_cfg[3] = '{21'd2048, 21'd400, 21'd300, 21'd260, 21'd700};
        phase_cfg[4] = '{21'd300, 21'd0, 21'd0, 21'h1F_FFFF, 21'h1F_FFFF};
        phase_items[0] = 450;
        phase_items[1] = 300;
        phase_items[2] = 150;
        phase_items[3] = 350;
        phase_items[4] = 300;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_setting) begin
                settle();
                write_reg(plan[i].reg_index, plan[i].reg_value);
            end else begin
                issue(plan[i].rq, plan[i].typed, plan[i].known);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            apply_setting(phase_cfg[p]);
            for (int unsigned n = 0; n < phase_items[p]; n++) begin
                // Halfway through each phase the block is allowed to run dry.
                if (n == phase_items[p] / 2) settle();
                issue(random_request(), 1'b0, '0);
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Reply side: stalls a drawn number of cycles before each reply, then stays ready
    // until that reply has been taken.
    initial begin : reply_sink
        int unsigned stall;
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = draw_wait(SINK);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
        end
    end

    // Every reply taken is checked against the oldest prediction still waiting.
    always @(posedge i_clk) begin : reply_check
        t_resp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            replies_seen++;
            if (pending_replies.size() == 0) begin
                report($sformatf("reply %0d arrived with none owed: %p",
                                 replies_seen, o_out_resp));
            end else begin
                want = pending_replies.pop_front();
                if (o_out_resp.status !== want.status ||
                    o_out_resp.page_address !== want.page_address ||
                    o_out_resp.is_free !== want.is_free ||
                    o_out_resp.free_pages !== want.free_pages) begin
                    report($sformatf({"reply %0d got/owed: status %0d/%0d addr %h/%h ",
                                      "is_free %b/%b count %0d/%0d"}, replies_seen,
                                     o_out_resp.status, want.status,
                                     o_out_resp.page_address, want.page_address,
                                     o_out_resp.is_free, want.is_free,
                                     o_out_resp.free_pages, want.free_pages));
                end
            end
        end
    end

    // The run is hung if neither a request nor a reply moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
